/* rtl/crds_pkg.sv */
// crds_pkg: shared types, codes and defaults for the container relocation
// destination select block. No dependencies; every rtl file imports it.
package crds_pkg;

   // default sizing of the yard
   localparam int DEF_NUM_STACKS = 32;
   localparam int DEF_MAX_TIERS  = 8;
   localparam int DEF_ID_BITS    = 10;

   // csr map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MAX_HEIGHT    = 1'b0;
   localparam logic CSR_IDX_STACKS_IN_USE = 1'b1;
   localparam logic [3:0] RST_MAX_HEIGHT    = 4'd4;
   localparam logic [5:0] RST_STACKS_IN_USE = 6'd16;

   // commands
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PUSH  = 2'd1;
   localparam logic [1:0] CMD_RELOC = 2'd2;

   // destination rules
   localparam logic [3:0] RULE_SPACE  = 4'd1;
   localparam logic [3:0] RULE_RI     = 4'd2;
   localparam logic [3:0] RULE_RIL    = 4'd3;
   localparam logic [3:0] RULE_RI_R   = 4'd4;
   localparam logic [3:0] RULE_RIL_R  = 4'd5;
   localparam logic [3:0] RULE_TOP    = 4'd6;
   localparam logic [3:0] RULE_MINSP  = 4'd7;
   localparam logic [3:0] RULE_RI_INV = 4'd8;

   // result status
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_EMPTY   = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_NO_DEST = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] stack_index;
      logic [9:0] container_id;
      logic [3:0] heuristic;
   } req_type;

   typedef struct packed {
      logic [4:0] dest_stack;
      logic [9:0] moved_container;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOPGET,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_DECIDE,
      ST_RESP
   } crds_state_type;

endpackage

/* rtl/crds_yard_mem.sv */
// crds_yard_mem: yard storage, one row per stack, one id per tier.
// Lane write, whole-row registered read. Uses crds_pkg.
module crds_yard_mem
   import crds_pkg::*;
#(
   parameter int NUM_STACKS = DEF_NUM_STACKS,
   parameter int MAX_TIERS  = DEF_MAX_TIERS,
   parameter int ID_BITS    = DEF_ID_BITS,
   localparam int SIDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
   localparam int TW        = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [SIDX_W-1:0]                 wr_row,
   input  logic [TW-1:0]                     wr_lane,
   input  logic [ID_BITS-1:0]                wr_data,
   input  logic [SIDX_W-1:0]                 rd_row,
   output logic [MAX_TIERS-1:0][ID_BITS-1:0] rd_data
);

   logic [MAX_TIERS-1:0][ID_BITS-1:0] mem_ff [NUM_STACKS];
   logic [MAX_TIERS-1:0][ID_BITS-1:0] rd_data_ff;

   // write one tier of a row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row][wr_lane] <= wr_data;
      end
   end

   // registered row read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/crds_row_eval.sv */
// crds_row_eval: shared evaluation unit for one stack row: ids below the
// moving id (count and highest) and the top id. Uses crds_pkg.
module crds_row_eval
   import crds_pkg::*;
#(
   parameter int MAX_TIERS = DEF_MAX_TIERS,
   parameter int ID_BITS   = DEF_ID_BITS,
   localparam int HT_W     = $clog2(MAX_TIERS + 1),
   localparam int TW       = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1
) (
   input  logic [MAX_TIERS-1:0][ID_BITS-1:0] row,
   input  logic [HT_W-1:0]                   height,
   input  logic [ID_BITS-1:0]                cval,
   output logic [HT_W-1:0]                   lower_cnt,
   output logic [ID_BITS-1:0]                lower_high,
   output logic [ID_BITS-1:0]                top_id
);

   // tier compares in parallel, count and max over occupied tiers
   always_comb begin
      lower_cnt  = '0;
      lower_high = '0;
      for (int t = 0; t < MAX_TIERS; t++) begin
         if ((HT_W'(t) < height) && (row[t] < cval)) begin
            lower_cnt = lower_cnt + HT_W'(1);
            if (row[t] > lower_high) begin
               lower_high = row[t];
            end
         end
      end
   end

   // top id; only used when height is nonzero
   assign top_id = row[TW'(height - HT_W'(1))];

endmodule

/* rtl/container_relocation_destination_select.sv */
// container_relocation_destination_select: top level, sequencer, stack
// heights and csrs. Uses crds_pkg, crds_yard_mem, crds_row_eval.
//
// Usage: commands arrive as words on req_* (valid/stall), and each gives one
// result word on rsp_* (valid/stall). For clear, push, unknown commands and
// an empty or out-of-range origin, the sequencer goes from accept straight
// to the response state. A relocation with a bad rule goes there after the
// origin top read and reports no destination. A relocation reads the origin
// top, then visits every stack in use with a row read, then one pass through
// the shared row evaluation unit. It then commits the move or reports no
// destination. The yard memory's single read port and the one evaluation
// unit make the scan visit one stack at a time. One command is worked at a
// time. req_stall is high until the result sits in the output register. A
// held output register does not block a new accept, but the next result
// waits while rsp_stall is high. Reset (synchronous) empties all stacks and
// loads max_height 4, stacks_in_use 16. Yard contents are not cleared, since
// only pushed tiers are ever read. Config goes through the csr_* port at
// byte addresses 0 and 4, written while idle.
module container_relocation_destination_select
   import crds_pkg::*;
#(
   parameter int NUM_STACKS = DEF_NUM_STACKS,
   parameter int MAX_TIERS  = DEF_MAX_TIERS,
   parameter int ID_BITS    = DEF_ID_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int NS_W   = $clog2(NUM_STACKS + 1);
   localparam int HT_W   = $clog2(MAX_TIERS + 1);
   localparam int TW     = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1;
   localparam int IDX_W  = (ID_BITS > 10) ? ID_BITS : 10;
   localparam int SX_W   = (SIDX_W > 5) ? SIDX_W : 5;

   crds_state_type state_ff, state_in;

   logic [3:0] mh_reg_ff;
   logic [5:0] siu_reg_ff;
   logic       csr_wr;

   logic [HT_W-1:0] hgt_ff [NUM_STACKS];
   logic            hgt_clr, hgt_inc_en, hgt_dec_en;
   logic [SIDX_W-1:0] hgt_inc_idx, hgt_dec_idx;

   rsp_type res_ff, res_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_load;

   logic [SIDX_W-1:0]  org_ff, org_in;
   logic [HT_W-1:0]    h_org_ff, h_org_in;
   logic [3:0]         rule_ff, rule_in;
   logic [ID_BITS-1:0] c_ff, c_in;
   logic [NS_W-1:0]    k_ff, k_in;
   logic [SIDX_W-1:0]  i_ff, i_in;
   logic [HT_W-1:0]    h_scan_ff, h_scan_in;
   logic [HT_W-1:0]    best_cnt_ff, best_cnt_in;
   logic [ID_BITS-1:0] best_hi_ff, best_hi_in;
   logic               found_ff, found_in;
   logic [SIDX_W-1:0]  pick_ff, pick_in;
   logic               up_ok_ff, up_ok_in, dn_ok_ff, dn_ok_in;
   logic [ID_BITS-1:0] up_d_ff, up_d_in, dn_d_ff, dn_d_in;
   logic [SIDX_W-1:0]  up_s_ff, up_s_in, dn_s_ff, dn_s_in;

   logic                              mem_we;
   logic [SIDX_W-1:0]                 mem_wrow, mem_rrow;
   logic [TW-1:0]                     mem_wlane;
   logic [ID_BITS-1:0]                mem_wdata;
   logic [MAX_TIERS-1:0][ID_BITS-1:0] row_q;

   logic [HT_W-1:0]    ev_cnt;
   logic [ID_BITS-1:0] ev_high, ev_top;

   logic [6:0]         ns7;
   logic [4:0]         mh5;
   logic [NS_W-1:0]    ns;
   logic [HT_W-1:0]    mh;
   logic               req_acc;
   logic [SIDX_W-1:0]  s_idx;
   logic               s_ok;
   logic [IDX_W-1:0]   id_ext;
   logic [ID_BITS-1:0] id_val;
   logic [SIDX_W-1:0]  hidx;
   logic [HT_W-1:0]    h_rd;
   logic               scan_right, last_scan, rule_ok, ri_rule, ril;
   logic [SIDX_W-1:0]  scan_i;
   logic               is_org, full;
   logic [HT_W-1:0]    sp;
   logic [SIDX_W-1:0]  d_sel;
   logic               d_valid, move_ok;
   logic [ID_BITS-1:0] diff_up, diff_dn;

   // effective config values
   always_comb begin
      if (7'(siu_reg_ff) < 7'd2) begin
         ns7 = 7'd2;
      end else if (7'(siu_reg_ff) > 7'(NUM_STACKS)) begin
         ns7 = 7'(NUM_STACKS);
      end else begin
         ns7 = 7'(siu_reg_ff);
      end
      if (5'(mh_reg_ff) < 5'd1) begin
         mh5 = 5'd1;
      end else if (5'(mh_reg_ff) > 5'(MAX_TIERS)) begin
         mh5 = 5'(MAX_TIERS);
      end else begin
         mh5 = 5'(mh_reg_ff);
      end
   end
   assign ns = NS_W'(ns7);
   assign mh = HT_W'(mh5);

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_STACKS_IN_USE) ?
                       CSR_DATA_W'(siu_reg_ff) : CSR_DATA_W'(mh_reg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mh_reg_ff  <= RST_MAX_HEIGHT;
         siu_reg_ff <= RST_STACKS_IN_USE;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_MAX_HEIGHT) begin
            mh_reg_ff <= csr_pwdata[3:0];
         end else begin
            siu_reg_ff <= csr_pwdata[5:0];
         end
      end
   end

   // request decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign s_idx     = SIDX_W'(req_word.stack_index);
   assign s_ok      = 7'(req_word.stack_index) < ns7;
   assign id_ext    = IDX_W'(req_word.container_id);
   assign id_val    = id_ext[ID_BITS-1:0];

   // scan order and rule classes
   assign scan_right = (rule_ff == RULE_RI_R) || (rule_ff == RULE_RIL_R);
   assign scan_i     = scan_right ? SIDX_W'(ns - NS_W'(1) - k_ff) : SIDX_W'(k_ff);
   assign last_scan  = (k_ff + NS_W'(1)) == ns;
   assign rule_ok    = (rule_ff >= RULE_SPACE) && (rule_ff <= RULE_RI_INV);
   assign ri_rule    = (rule_ff >= RULE_RI) && (rule_ff <= RULE_RIL_R);
   assign ril        = (rule_ff == RULE_RIL) || (rule_ff == RULE_RIL_R);

   // destination after the scan
   always_comb begin
      d_sel   = pick_ff;
      d_valid = 1'b1;
      if (rule_ff == RULE_TOP) begin
         if (up_ok_ff) begin
            d_sel = up_s_ff;
         end else if (dn_ok_ff) begin
            d_sel = dn_s_ff;
         end else begin
            d_sel = (org_ff == '0) ? SIDX_W'(1) : '0;
         end
      end else if (rule_ff == RULE_MINSP) begin
         d_valid = found_ff;
      end
   end

   // height read port shared by request, scan and decide
   always_comb begin
      unique case (state_ff)
         ST_SCAN_RD: hidx = scan_i;
         ST_DECIDE:  hidx = d_sel;
         default:    hidx = s_idx;
      endcase
   end
   assign h_rd    = hgt_ff[hidx];
   assign move_ok = d_valid && (7'(d_sel) < ns7) && (d_sel != org_ff) && (h_rd < mh);

   // yard memory and evaluation unit
   crds_yard_mem #(
      .NUM_STACKS (NUM_STACKS),
      .MAX_TIERS  (MAX_TIERS),
      .ID_BITS    (ID_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_row  (mem_wrow),
      .wr_lane (mem_wlane),
      .wr_data (mem_wdata),
      .rd_row  (mem_rrow),
      .rd_data (row_q)
   );

   crds_row_eval #(
      .MAX_TIERS (MAX_TIERS),
      .ID_BITS   (ID_BITS)
   ) u_eval (
      .row        (row_q),
      .height     (h_scan_ff),
      .cval       (c_ff),
      .lower_cnt  (ev_cnt),
      .lower_high (ev_high),
      .top_id     (ev_top)
   );

   // per-stack candidate terms
   assign is_org  = (i_ff == org_ff);
   assign full    = (h_scan_ff >= mh);
   assign sp      = full ? '0 : (mh - h_scan_ff);
   assign diff_up = ev_top - c_ff;
   assign diff_dn = c_ff - ev_top;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if ((req_word.cmd == CMD_RELOC) && s_ok && (h_rd != '0)) begin
                  state_in = ST_TOPGET;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_TOPGET:  state_in = rule_ok ? ST_SCAN_RD : ST_RESP;
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: state_in = last_scan ? ST_DECIDE : ST_SCAN_RD;
         ST_DECIDE:  state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      res_in      = res_ff;
      org_in      = org_ff;
      h_org_in    = h_org_ff;
      rule_in     = rule_ff;
      c_in        = c_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      h_scan_in   = h_scan_ff;
      best_cnt_in = best_cnt_ff;
      best_hi_in  = best_hi_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      up_ok_in    = up_ok_ff;
      dn_ok_in    = dn_ok_ff;
      up_d_in     = up_d_ff;
      dn_d_in     = dn_d_ff;
      up_s_in     = up_s_ff;
      dn_s_in     = dn_s_ff;
      hgt_clr     = 1'b0;
      hgt_inc_en  = 1'b0;
      hgt_dec_en  = 1'b0;
      hgt_inc_idx = s_idx;
      hgt_dec_idx = org_ff;
      mem_we      = 1'b0;
      mem_wrow    = s_idx;
      mem_wlane   = TW'(h_rd);
      mem_wdata   = id_val;
      mem_rrow    = s_idx;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_in  = '0;
               org_in  = s_idx;
               h_org_in = h_rd;
               rule_in = req_word.heuristic;
               unique case (req_word.cmd)
                  CMD_CLEAR: hgt_clr = 1'b1;
                  CMD_PUSH: begin
                     if (!s_ok || (h_rd >= mh)) begin
                        res_in.status = STS_FULL;
                     end else begin
                        mem_we                 = 1'b1;
                        hgt_inc_en             = 1'b1;
                        res_in.dest_stack      = req_word.stack_index;
                        res_in.moved_container = 10'(id_val);
                     end
                  end
                  CMD_RELOC: begin
                     if (!s_ok || (h_rd == '0)) begin
                        res_in.status = STS_EMPTY;
                     end
                  end
                  default: res_in = '0;
               endcase
            end
         end
         ST_TOPGET: begin
            // origin top is the moving id; reset the running best
            c_in        = row_q[TW'(h_org_ff - HT_W'(1))];
            k_in        = '0;
            best_cnt_in = ri_rule ? hgt_ff[0] : '0;
            best_hi_in  = '0;
            found_in    = 1'b0;
            pick_in     = '0;
            up_ok_in    = 1'b0;
            dn_ok_in    = 1'b0;
            if (!rule_ok) begin
               res_in.status = STS_NO_DEST;
            end
         end
         ST_SCAN_RD: begin
            mem_rrow  = scan_i;
            i_in      = scan_i;
            h_scan_in = h_rd;
         end
         ST_SCAN_EV: begin
            k_in = k_ff + NS_W'(1);
            if (rule_ff == RULE_SPACE) begin
               if (!is_org && (sp > best_cnt_ff)) begin
                  best_cnt_in = sp;
                  pick_in     = i_ff;
               end
            end else if (!is_org && !full) begin
               if (ri_rule) begin
                  if (best_cnt_ff > ev_cnt) begin
                     best_cnt_in = ev_cnt;
                     best_hi_in  = ev_high;
                     pick_in     = i_ff;
                  end else if (ril && (best_cnt_ff == ev_cnt) && (ev_high > best_hi_ff)) begin
                     best_hi_in = ev_high;
                     pick_in    = i_ff;
                  end
               end else if (rule_ff == RULE_TOP) begin
                  if (h_scan_ff != '0) begin
                     if (ev_top > c_ff) begin
                        if (!up_ok_ff || (diff_up < up_d_ff)) begin
                           up_ok_in = 1'b1;
                           up_d_in  = diff_up;
                           up_s_in  = i_ff;
                        end
                     end else if (c_ff > ev_top) begin
                        if (!dn_ok_ff || (diff_dn < dn_d_ff)) begin
                           dn_ok_in = 1'b1;
                           dn_d_in  = diff_dn;
                           dn_s_in  = i_ff;
                        end
                     end
                  end
               end else if (rule_ff == RULE_MINSP) begin
                  if (!found_ff || (sp < best_cnt_ff)) begin
                     found_in    = 1'b1;
                     best_cnt_in = sp;
                     pick_in     = i_ff;
                  end
               end else begin
                  // most lower ids
                  if (!found_ff || (ev_cnt > best_cnt_ff)) begin
                     found_in    = 1'b1;
                     best_cnt_in = ev_cnt;
                     pick_in     = i_ff;
                  end
               end
            end
         end
         ST_DECIDE: begin
            if (move_ok) begin
               mem_we      = 1'b1;
               mem_wrow    = d_sel;
               mem_wdata   = c_ff;
               hgt_dec_en  = 1'b1;
               hgt_inc_en  = 1'b1;
               hgt_inc_idx = d_sel;
               res_in.dest_stack      = SX_W'(d_sel) > SX_W'(31) ? 5'(d_sel) : 5'(d_sel);
               res_in.moved_container = 10'(c_ff);
               res_in.status          = STS_OK;
            end else begin
               res_in = '0;
               res_in.status = STS_NO_DEST;
            end
         end
         ST_RESP: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: res_in = res_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stack heights
   always_ff @(posedge clock) begin
      if (reset || hgt_clr) begin
         for (int s = 0; s < NUM_STACKS; s++) begin
            hgt_ff[s] <= '0;
         end
      end else begin
         if (hgt_dec_en) begin
            hgt_ff[hgt_dec_idx] <= hgt_ff[hgt_dec_idx] - HT_W'(1);
         end
         if (hgt_inc_en) begin
            hgt_ff[hgt_inc_idx] <= hgt_ff[hgt_inc_idx] + HT_W'(1);
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      org_ff      <= org_in;
      h_org_ff    <= h_org_in;
      rule_ff     <= rule_in;
      c_ff        <= c_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      h_scan_ff   <= h_scan_in;
      best_cnt_ff <= best_cnt_in;
      best_hi_ff  <= best_hi_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      up_ok_ff    <= up_ok_in;
      dn_ok_ff    <= dn_ok_in;
      up_d_ff     <= up_d_in;
      dn_d_ff     <= dn_d_in;
      up_s_ff     <= up_s_in;
      dn_s_ff     <= dn_s_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_acc_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start a command");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result word raised outside response state");

   a_move_has_origin: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DECIDE) && move_ok) |-> (h_org_ff != '0))
      else $error("relocation from an empty origin");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN_RD) || (state_ff == ST_SCAN_EV)) |-> (k_ff < ns))
      else $error("scan counter past stacks in use");
`endif

endmodule
